// ===== rtl/isl_pkg.sv =====
// Shared types, codes and sizes for the indexed shift list.
`default_nettype none

package isl_pkg;

  // Store size and field widths.
  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = 7;
  localparam int WORD_W     = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Request kinds.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_INSERT     = 3'd4;
  localparam logic [2:0] KIND_REMOVE     = 3'd5;
  localparam logic [2:0] KIND_DUMP       = 3'd6;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_BADPOS = 2'd3;

  // Store operations handed from the front end to the back end.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  typedef struct packed {
    logic [2:0]               kind;
    logic [CNT_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/isl_front.sv =====
// Front end: takes requests, checks them against the list length, issues commands.
`default_nettype none

module isl_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  isl_pkg::req_t    req,
  input  wire              queue_full,
  output logic             cmd_push,
  output isl_pkg::cmd_t    cmd
);

  logic [isl_pkg::CNT_W-1:0] length;
  logic [isl_pkg::CNT_W-1:0] length_next;
  logic                      is_full;
  logic                      is_empty;
  logic                      ins_bad;
  logic                      rem_bad;

  assign req_ready = !queue_full;
  assign cmd_push  = req_valid && req_ready;

  assign is_full  = length >= isl_pkg::CNT_W'(isl_pkg::CAPACITY);
  assign is_empty = length == '0;
  assign ins_bad  = (req.position == '0) ||
                    ({1'b0, req.position} > ({1'b0, length} + 8'd1));
  assign rem_bad  = (req.position == '0) || (req.position > length);

  always_comb begin
    cmd.op      = isl_pkg::OP_NONE;
    cmd.idx     = '0;
    cmd.value   = req.value;
    cmd.status  = isl_pkg::STAT_OK;
    length_next = length;
    unique case (req.kind)
      isl_pkg::KIND_PUSH_FRONT: begin
        if (is_full) begin
          cmd.status = isl_pkg::STAT_FULL;
        end else begin
          cmd.op      = isl_pkg::OP_PUT;
          length_next = length + 1'b1;
        end
      end
      isl_pkg::KIND_POP_FRONT: begin
        if (is_empty) begin
          cmd.status = isl_pkg::STAT_EMPTY;
        end else begin
          cmd.op      = isl_pkg::OP_TAKE;
          length_next = length - 1'b1;
        end
      end
      isl_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          cmd.status = isl_pkg::STAT_FULL;
        end else begin
          cmd.op      = isl_pkg::OP_PUT;
          cmd.idx     = isl_pkg::IDX_W'(length);
          length_next = length + 1'b1;
        end
      end
      isl_pkg::KIND_POP_BACK: begin
        // Dropping the tail only moves the length; the store is untouched.
        if (is_empty) begin
          cmd.status = isl_pkg::STAT_EMPTY;
        end else begin
          length_next = length - 1'b1;
        end
      end
      isl_pkg::KIND_INSERT: begin
        if (ins_bad) begin
          cmd.status = isl_pkg::STAT_BADPOS;
        end else if (is_full) begin
          cmd.status = isl_pkg::STAT_FULL;
        end else begin
          cmd.op      = isl_pkg::OP_PUT;
          cmd.idx     = isl_pkg::IDX_W'(req.position - 1'b1);
          length_next = length + 1'b1;
        end
      end
      isl_pkg::KIND_REMOVE: begin
        if (is_empty) begin
          cmd.status = isl_pkg::STAT_EMPTY;
        end else if (rem_bad) begin
          cmd.status = isl_pkg::STAT_BADPOS;
        end else begin
          cmd.op      = isl_pkg::OP_TAKE;
          cmd.idx     = isl_pkg::IDX_W'(req.position - 1'b1);
          length_next = length - 1'b1;
        end
      end
      isl_pkg::KIND_DUMP: begin
        if (is_empty) begin
          cmd.status = isl_pkg::STAT_EMPTY;
        end else begin
          cmd.op = isl_pkg::OP_DUMP;
        end
      end
      default: begin
      end
    endcase
    cmd.count = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd_push) begin
      length <= length_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isl_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module isl_fifo (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  isl_pkg::cmd_t    push_data,
  output logic             full,
  input  wire              pop,
  output isl_pkg::cmd_t    pop_data,
  output logic             empty
);

  isl_pkg::cmd_t                  slot [isl_pkg::FIFO_DEPTH];
  logic [isl_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [isl_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [isl_pkg::FIFO_CNT_W-1:0] fill;

  assign full     = fill == isl_pkg::FIFO_CNT_W'(isl_pkg::FIFO_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == isl_pkg::FIFO_PTR_W'(isl_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == isl_pkg::FIFO_PTR_W'(isl_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isl_back.sv =====
// Back end: row of shifting word cells and the registered response stage.
`default_nettype none

module isl_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              cmd_valid,
  input  isl_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output isl_pkg::rsp_t    rsp
);

  localparam logic ST_EXEC = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                      state;
  logic [isl_pkg::CNT_W-1:0] dump_len;
  logic [isl_pkg::CNT_W-1:0] dump_left;
  logic [isl_pkg::CNT_W-1:0] rot_len;

  logic signed [isl_pkg::WORD_W-1:0] entry      [isl_pkg::CAPACITY];
  logic signed [isl_pkg::WORD_W-1:0] entry_next [isl_pkg::CAPACITY];

  logic          advance;
  logic          load_rsp;
  logic          do_put;
  logic          do_take;
  logic          do_rot;
  isl_pkg::rsp_t rsp_next;

  assign advance  = !rsp_valid || rsp_ready;
  assign cmd_pop  = (state == ST_EXEC) && cmd_valid && advance;
  assign load_rsp = advance && ((state == ST_DUMP) || cmd_valid);
  assign do_put   = cmd_pop && (cmd.op == isl_pkg::OP_PUT);
  assign do_take  = cmd_pop && (cmd.op == isl_pkg::OP_TAKE);
  assign do_rot   = advance && ((state == ST_DUMP) ||
                               (cmd_pop && (cmd.op == isl_pkg::OP_DUMP)));
  assign rot_len  = (state == ST_DUMP) ? dump_len : cmd.count;

  // A dump reads the head cell and rotates the live part of the row by one,
  // so the list is back in place after the last entry goes out.
  always_comb begin
    rsp_next.status  = isl_pkg::STAT_OK;
    rsp_next.element = entry[0];
    rsp_next.count   = cmd.count;
    rsp_next.last    = 1'b1;
    priority if (state == ST_DUMP) begin
      rsp_next.count = dump_len;
      rsp_next.last  = dump_left == isl_pkg::CNT_W'(1);
    end else if (cmd.op == isl_pkg::OP_DUMP) begin
      rsp_next.last  = cmd.count == isl_pkg::CNT_W'(1);
    end else begin
      rsp_next.status  = cmd.status;
      rsp_next.element = '0;
    end
  end

  for (genvar g = 0; g < isl_pkg::CAPACITY; g++) begin : g_entry
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == isl_pkg::CAPACITY - 1) ? g : g + 1;

    always_comb begin
      entry_next[g] = entry[g];
      if (do_put) begin
        if (isl_pkg::IDX_W'(g) == cmd.idx) begin
          entry_next[g] = cmd.value;
        end else if (isl_pkg::IDX_W'(g) > cmd.idx) begin
          entry_next[g] = entry[PREV];
        end
      end else if (do_take) begin
        if (isl_pkg::IDX_W'(g) >= cmd.idx) begin
          entry_next[g] = entry[NEXT];
        end
      end else if (do_rot) begin
        if (isl_pkg::CNT_W'(g) == rot_len - 1'b1) begin
          entry_next[g] = entry[0];
        end else if ((isl_pkg::CNT_W'(g) + 1'b1) < rot_len) begin
          entry_next[g] = entry[NEXT];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EXEC;
      rsp_valid <= 1'b0;
      dump_len  <= '0;
      dump_left <= '0;
    end else begin
      if (advance) begin
        rsp_valid <= load_rsp;
      end
      unique case (state)
        ST_EXEC: begin
          if (cmd_pop && (cmd.op == isl_pkg::OP_DUMP) && (cmd.count != isl_pkg::CNT_W'(1))) begin
            state     <= ST_DUMP;
            dump_len  <= cmd.count;
            dump_left <= cmd.count - 1'b1;
          end
        end
        ST_DUMP: begin
          if (advance) begin
            dump_left <= dump_left - 1'b1;
            if (dump_left == isl_pkg::CNT_W'(1)) begin
              state <= ST_EXEC;
            end
          end
        end
        default: state <= ST_EXEC;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/indexed_shift_list.sv =====
// Top level of the indexed shift list: front end, command queue and back end.
// A request accepted by the front end is written into the command queue; the back end
// then takes it from the queue and registers its first response in the response stage.
// The front end takes one request per cycle while the queue has room. A dump holds
// the back end and sends one entry per cycle out of the head cell while rsp_ready is high.
// Reset (rst, synchronous): clears the length, the queue and the response valid;
// the word cells are not cleared and are only read below the length.
`default_nettype none

module indexed_shift_list (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  isl_pkg::req_t    req,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output isl_pkg::rsp_t    rsp
);

  // The front end keeps its own copy of the list length. Every request's
  // outcome depends on the length and the request alone, so the front end can decide the
  // status and the new length of each request as it arrives and run ahead
  // of the back end, which may still be busy with a dump.
  logic          queue_full;
  logic          queue_empty;
  logic          cmd_push;
  logic          cmd_pop;
  isl_pkg::cmd_t front_cmd;
  isl_pkg::cmd_t back_cmd;

  isl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  // The queue lets the front end keep taking requests while the back end
  // streams a dump or waits on a stalled response.
  isl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .empty     (queue_empty)
  );

  // The back end holds the words in a row of cells; for an insert or a remove the cells
  // from the position on shift together. It also drives the registered response.
  isl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!queue_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/isl_check.sv =====
// Port-level checker for the indexed shift list, bound to the top level.
`default_nettype none

module isl_check (
  input wire           clk,
  input wire           rst,
  input wire           rsp_valid,
  input wire           rsp_ready,
  input isl_pkg::rsp_t rsp
);

  // A stalled response holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // The count never exceeds the store size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= isl_pkg::CNT_W'(isl_pkg::CAPACITY))
    else $error("count above capacity");

  // Only dump entries of a non-empty list can be followed by more responses.
  a_mid_dump: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == isl_pkg::STAT_OK && rsp.count != '0)
    else $error("non-final response outside a dump");

  // Error responses stand alone and carry no element.
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != isl_pkg::STAT_OK |-> rsp.last && rsp.element == '0)
    else $error("error response is not a single empty result");

endmodule

bind indexed_shift_list isl_check u_isl_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ===== verif/indexed_shift_list_test.sv =====
// Self-checking testbench for the indexed shift list, with an in-line list mirror.
module indexed_shift_list_test;
  import isl_pkg::*;

  // The one kind code the block does not define; it must answer ok and leave the list alone.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  // Cycles allowed after the last expected response before the verdict.
  localparam int SETTLE_CYCLES = 8;

  // Hard stop for a hung run.
  localparam int RUN_LIMIT = 2_000_000;

  // Mirror of the list contents. It predicts the responses of every accepted request
  // and holds them until the block delivers them.
  class shift_list_mirror;
    logic signed [WORD_W-1:0] words[$];
    rsp_t pending_responses[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int length();
      return words.size();
    endfunction

    function int waiting();
      return pending_responses.size();
    endfunction

    // The count field always reflects the list after the operation.
    function void queue_response(logic [1:0] status, logic signed [WORD_W-1:0] element,
                                 logic last);
      rsp_t r;
      r.status  = status;
      r.element = element;
      r.count   = CNT_W'(words.size());
      r.last    = last;
      pending_responses.insert(pending_responses.size(), r);
    endfunction

    function void apply_request(req_t r);
      logic [1:0] status;
      int pos;
      int len;
      status = STAT_OK;
      pos    = int'(r.position);
      len    = words.size();
      case (r.kind)
        KIND_PUSH_FRONT: begin
          if (len >= CAPACITY) status = STAT_FULL;
          else words.insert(0, r.value);
        end
        KIND_POP_FRONT: begin
          if (len == 0) status = STAT_EMPTY;
          else words.delete(0);
        end
        KIND_PUSH_BACK: begin
          if (len >= CAPACITY) status = STAT_FULL;
          else words.insert(len, r.value);
        end
        KIND_POP_BACK: begin
          if (len == 0) status = STAT_EMPTY;
          else words.delete(len - 1);
        end
        KIND_INSERT: begin
          // The position is checked before fullness.
          if (pos < 1 || pos > len + 1) status = STAT_BADPOS;
          else if (len >= CAPACITY) status = STAT_FULL;
          else words.insert(pos - 1, r.value);
        end
        KIND_REMOVE: begin
          // Emptiness is checked before the position.
          if (len == 0) status = STAT_EMPTY;
          else if (pos < 1 || pos > len) status = STAT_BADPOS;
          else words.delete(pos - 1);
        end
        KIND_DUMP: begin
          if (len == 0) begin
            status = STAT_EMPTY;
          end else begin
            for (int i = 0; i < len; i++) queue_response(STAT_OK, words[i], i == len - 1);
            return;
          end
        end
        default: ;
      endcase
      queue_response(status, '0, 1'b1);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_responses.size() == 0) begin
        $error("response with nothing pending: status %0d element %0d count %0d last %0d",
               got.status, got.element, got.count, got.last);
        mismatch_count++;
        return;
      end
      want = pending_responses[0];
      pending_responses.delete(0);
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.element !== want.element) begin
        $error("element: expected %0d, got %0d", want.element, got.element);
        mismatch_count++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Idle rates of the two sides, in percent, changed from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  shift_list_mirror mirror;

  indexed_shift_list DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver decides its ready for the next edge on each falling edge.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) mirror.check_response(rsp);
  end

  initial begin
    #RUN_LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t make_request(logic [2:0] kind, int position,
                                        logic [WORD_W-1:0] value);
    req_t r;
    r.kind     = kind;
    r.position = CNT_W'(position);
    r.value    = value;
    return r;
  endfunction

  // Random request steered toward a target length. Most requests are legal pushes,
  // pops, inserts and removes; a few are dumps, unused kinds or bad positions.
  function automatic req_t random_request(int target);
    int len;
    int roll;
    int lean;
    int pick;
    logic grow;
    logic [2:0] kind;
    int position;
    logic [WORD_W-1:0] value;
    len      = mirror.length();
    roll     = $urandom_range(99);
    lean     = $urandom_range(99);
    pick     = $urandom_range(2);
    value    = $urandom();
    position = $urandom_range(127);
    kind     = KIND_UNUSED;
    if (roll < 5) begin
      kind = KIND_DUMP;
    end else if (roll < 7) begin
      kind = KIND_UNUSED;
    end else if (roll < 10) begin
      kind = pick[0] ? KIND_INSERT : KIND_REMOVE;
      if ($urandom_range(1) == 0) position = 0;
      else position = $urandom_range(127, (kind == KIND_INSERT) ? len + 2 : len + 1);
    end else begin
      if (len < target) grow = (lean < 95);
      else if (len > target) grow = (lean < 5);
      else grow = (lean < 50);
      if (grow) begin
        case (pick)
          0: kind = KIND_PUSH_FRONT;
          1: kind = KIND_PUSH_BACK;
          default: begin
            kind = KIND_INSERT;
            position = $urandom_range(len + 1, 1);
          end
        endcase
      end else begin
        case (pick)
          0: kind = KIND_POP_FRONT;
          1: kind = KIND_POP_BACK;
          default: begin
            kind = KIND_REMOVE;
            if (len > 0) position = $urandom_range(len, 1);
          end
        endcase
      end
    end
    return make_request(kind, position, value);
  endfunction

  // Offer one request, with random idle cycles ahead of it, and hold it until accepted.
  // Valid is left high after acceptance; the next call or a drain decides what follows.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
      req <= make_request(3'($urandom()), $urandom_range(127), $urandom());
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    mirror.apply_request(r);
  endtask

  // Stop sending until every predicted response has come back, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (mirror.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int target, int items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_request(random_request(target));
    drain_results();
  endtask

  initial begin
    mirror = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests: every kind, the empty-list answers, both position bounds,
    // the extreme words, and the unused kind.
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    send_request(make_request(KIND_DUMP, 0, '0));
    send_request(make_request(KIND_POP_FRONT, 0, '0));
    send_request(make_request(KIND_POP_BACK, 0, '0));
    send_request(make_request(KIND_REMOVE, 1, '0));
    send_request(make_request(KIND_INSERT, 2, 32'h1234_5678));
    send_request(make_request(KIND_INSERT, 0, 32'h1234_5678));
    send_request(make_request(KIND_INSERT, 1, 32'h7FFF_FFFF));
    send_request(make_request(KIND_PUSH_FRONT, 0, 32'h8000_0000));
    send_request(make_request(KIND_PUSH_BACK, 0, 32'h0000_0000));
    send_request(make_request(KIND_PUSH_BACK, 0, 32'hFFFF_FFFF));
    send_request(make_request(KIND_INSERT, 5, 32'h5555_5555));
    send_request(make_request(KIND_INSERT, 127, 32'h0F0F_0F0F));
    send_request(make_request(KIND_REMOVE, 0, '0));
    send_request(make_request(KIND_REMOVE, 6, '0));
    send_request(make_request(KIND_DUMP, 0, '0));
    send_request(make_request(KIND_REMOVE, 3, '0));
    send_request(make_request(KIND_REMOVE, 4, '0));
    send_request(make_request(KIND_UNUSED, 127, 32'hFFFF_FFFF));
    send_request(make_request(KIND_POP_FRONT, 0, '0));
    send_request(make_request(KIND_POP_BACK, 0, '0));
    send_request(make_request(KIND_DUMP, 0, '0));
    send_request(make_request(KIND_INSERT, 1, 32'hAAAA_AAAA));
    drain_results();

    // Random phases: fill the list to capacity, work at the full boundary, empty it
    // out again, then wander around a random length.
    run_phase(0, 0, CAPACITY, 65);
    run_phase(62, 0, CAPACITY, 30);
    run_phase(0, 62, 0, 45);
    run_phase(29, 29, $urandom_range(CAPACITY), 20);

    if (mirror.mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
